### rtl/tsc_pkg.sv
// tsc_pkg: shared types, event and gesture codes and scaling constants
// for the touch swipe classifier; no dependencies
`timescale 1ns / 1ps

package tsc_pkg;

	localparam int unsigned CoordW = 10;
	localparam int unsigned KindW  = 3;
	localparam int unsigned GestW  = 3;

	typedef logic [CoordW-1:0] coord_t;
	typedef logic [KindW-1:0]  kind_t;
	typedef logic [GestW-1:0]  gest_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

	// event kinds
	localparam kind_t EV_NONE    = 3'd0;
	localparam kind_t EV_ABS_X   = 3'd1;
	localparam kind_t EV_ABS_Y   = 3'd2;
	localparam kind_t EV_PRESS   = 3'd3;
	localparam kind_t EV_RELEASE = 3'd4;

	// gesture codes
	localparam gest_t G_TAP   = 3'd0;
	localparam gest_t G_RIGHT = 3'd1;
	localparam gest_t G_LEFT  = 3'd2;
	localparam gest_t G_DOWN  = 3'd3;
	localparam gest_t G_UP    = 3'd4;

	// x scale 800/1024 = 25/32
	localparam int unsigned XMul   = 25;
	localparam int unsigned XShift = 5;
	localparam int unsigned XProdW = CoordW + XShift;

	// y scale 480/600 = 4/5; divide by 5 as multiply by 3277 / 2^14,
	// exact for dividends below 4096
	localparam int unsigned YNumW   = CoordW + 2;
	localparam int unsigned YRecip  = 3277;
	localparam int unsigned YShift  = 14;
	localparam int unsigned YProdW  = YNumW + 12;

	localparam coord_t THRESH_RESET = 10'd50;

endpackage

### rtl/tsc_event_if.sv
// tsc_event_if: touch event channel, valid/ready with kind and raw value
// depends on tsc_pkg
`timescale 1ns / 1ps

interface tsc_event_if;
	import tsc_pkg::*;

	logic   valid;
	logic   ready;
	kind_t  event_kind;
	coord_t raw_value;

	modport source (output valid, output event_kind, output raw_value, input ready);
	modport sink   (input valid, input event_kind, input raw_value, output ready);
endinterface

### rtl/tsc_gesture_if.sv
// tsc_gesture_if: gesture result channel, valid/ready with gesture code
// depends on tsc_pkg
`timescale 1ns / 1ps

interface tsc_gesture_if;
	import tsc_pkg::*;

	logic  valid;
	logic  ready;
	gest_t gesture;

	modport source (output valid, output gesture, input ready);
	modport sink   (input valid, input gesture, output ready);
endinterface

### rtl/tsc_cfg_if.sv
// tsc_cfg_if: configuration write channel carrying the swipe threshold
// depends on tsc_pkg
`timescale 1ns / 1ps

interface tsc_cfg_if;
	import tsc_pkg::*;

	logic   valid;
	logic   ready;
	coord_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/tsc_classify.sv
// tsc_classify: gesture decision from start and current point
// depends on tsc_pkg
`timescale 1ns / 1ps

module tsc_classify
	import tsc_pkg::*;
(
	input  point_t start_pt,
	input  point_t cur_pt,
	input  coord_t thresh,
	output gest_t  gesture
);

	coord_t dx_pos, dx_neg, dy_pos, dy_neg;

	assign dx_pos = cur_pt.x - start_pt.x;
	assign dx_neg = start_pt.x - cur_pt.x;
	assign dy_pos = cur_pt.y - start_pt.y;
	assign dy_neg = start_pt.y - cur_pt.y;

	always_comb begin
		priority if (start_pt.x < cur_pt.x && dx_pos >= thresh) begin
			gesture = G_RIGHT;
		end else if (start_pt.x > cur_pt.x && dx_neg >= thresh) begin
			gesture = G_LEFT;
		end else if (start_pt.y < cur_pt.y && dy_pos >= thresh) begin
			gesture = G_DOWN;
		end else if (start_pt.y > cur_pt.y && dy_neg >= thresh) begin
			gesture = G_UP;
		end else begin
			gesture = G_TAP;
		end
	end

endmodule

### rtl/touch_swipe_classifier.sv
// touch_swipe_classifier: top level of the touch swipe gesture detector
// depends on tsc_pkg, tsc_event_if, tsc_gesture_if, tsc_cfg_if, tsc_classify
`timescale 1ns / 1ps

// usage
//   evt  : touch event words (event_kind, raw_value), one per cycle at most
//   gest : one gesture word for every touch release event
//   cfg  : write of the swipe threshold, always ready; write only when idle
// timing
//   an event is captured in the input register, then scaled, stored or
//   classified from there; a gesture is valid once its release has moved
//   from the input register into the gesture output register; throughput
//   is one event per cycle while no release stalls, set by the single input
//   register feeding the point registers and the gesture output register
// reset
//   arst_n low clears all points to zero, threshold to 50, both channels empty
// stall
//   a release waiting in the input register holds while the gesture register
//   is full and gest.ready is low; other kinds keep flowing, and evt.ready
//   drops only while the input register cannot move

module touch_swipe_classifier
	import tsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	tsc_event_if.sink     evt,
	tsc_gesture_if.source gest,
	tsc_cfg_if.sink       cfg
);

	// input register
	logic   vld_s1;
	kind_t  kind_s1;
	coord_t raw_s1;

	// block state
	point_t cur_q;
	point_t start_q;
	coord_t thresh_q;

	// output register
	logic  gest_vld_q;
	gest_t gest_q;

	logic  adv_s1;
	logic  is_rel_s1;
	gest_t gest_next;

	logic [XProdW-1:0] x_prod;
	logic [YProdW-1:0] y_prod;
	coord_t            x_scaled;
	coord_t            y_scaled;

	// a release needs room in the output register, other kinds always move
	assign is_rel_s1 = (kind_s1 == EV_RELEASE);
	assign adv_s1    = vld_s1 && (!is_rel_s1 || !gest_vld_q || gest.ready);
	assign evt.ready = !vld_s1 || adv_s1;
	assign cfg.ready = 1'b1;

	assign gest.valid   = gest_vld_q;
	assign gest.gesture = gest_q;

	// x * 25 >> 5
	assign x_prod   = XProdW'(raw_s1) * XProdW'(XMul);
	assign x_scaled = x_prod[XProdW-1 -: CoordW];

	// (y * 4) / 5 via reciprocal
	assign y_prod   = YProdW'({raw_s1, 2'b00}) * YProdW'(YRecip);
	assign y_scaled = y_prod[YShift +: CoordW];

	tsc_classify u_classify (
		.start_pt (start_q),
		.cur_pt   (cur_q),
		.thresh   (thresh_q),
		.gesture  (gest_next)
	);

	// input capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (evt.ready) begin
			vld_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			kind_s1 <= evt.event_kind;
			raw_s1  <= evt.raw_value;
		end
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid) begin
			thresh_q <= cfg.data;
		end
	end

	// point state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			start_q <= '0;
		end else if (adv_s1) begin
			unique case (kind_s1)
				EV_ABS_X: begin
					cur_q.x <= x_scaled;
				end
				EV_ABS_Y: begin
					cur_q.y <= y_scaled;
				end
				EV_PRESS: begin
					start_q <= cur_q;
				end
				EV_RELEASE: begin
					// each gesture starts again from the origin
					start_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// gesture output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gest_vld_q <= 1'b0;
		end else if (adv_s1 && is_rel_s1) begin
			gest_vld_q <= 1'b1;
		end else if (gest.ready) begin
			gest_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && is_rel_s1) begin
			gest_q <= gest_next;
		end
	end

endmodule

### verif/touch_swipe_classifier_test.sv
// touch_swipe_classifier_test: self-checking bench for the touch swipe classifier,
// a directed event table then random strokes checked against a gesture predictor
// depends on tsc_pkg, tsc_event_if, tsc_gesture_if, tsc_cfg_if, touch_swipe_classifier
`timescale 1ns / 1ps

module touch_swipe_classifier_test
	import tsc_pkg::*;
();

	// kinds with no meaning, the block must ignore them
	localparam kind_t EV_SPARE5 = 3'd5;
	localparam kind_t EV_SPARE6 = 3'd6;
	localparam kind_t EV_SPARE7 = 3'd7;

	localparam int unsigned PHASE_WORDS = 220;
	localparam int unsigned NROWS       = 30;

	typedef enum logic {ROW_EVENT, ROW_THRESH} row_op_t;

	// one directed row: an event word, or a threshold write carried in value
	typedef struct {
		row_op_t op;
		kind_t   kind;
		coord_t  value;
		bit      fixed;
		gest_t   gest;
	} row_t;

	logic clk;
	logic arst_n;

	tsc_event_if   evt_ch ();
	tsc_gesture_if gest_ch ();
	tsc_cfg_if     cfg_ch ();

	touch_swipe_classifier u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.gest   (gest_ch),
		.cfg    (cfg_ch)
	);

	// predictor state, a mirror of the block's points and threshold
	point_t now_pt;
	point_t start_pt;
	coord_t thresh_now;

	// gestures still owed by the block, oldest first
	gest_t gesture_due [$];

	// expectation typed into the current directed row, seen by the monitor
	bit    row_fixed;
	gest_t row_gest;

	bit          calm;
	int unsigned words_sent;
	int unsigned fault_count;

	// directed part: extremes, every kind, ignored kinds and raw values,
	// release without press, exact threshold, zero and full threshold
	row_t plan [NROWS] = '{
		// release straight after reset measures from zero
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b1, G_TAP},
		'{ROW_EVENT,  EV_ABS_X,   10'd1023, 1'b0, G_TAP},
		// raw value on a release has no effect
		'{ROW_EVENT,  EV_RELEASE, 10'd517,  1'b1, G_RIGHT},
		'{ROW_EVENT,  EV_PRESS,   10'd1023, 1'b0, G_TAP},
		'{ROW_EVENT,  EV_ABS_X,   10'd0,    1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b1, G_LEFT},
		// ignored and unknown kinds leave the points alone
		'{ROW_EVENT,  EV_NONE,    10'd1023, 1'b0, G_TAP},
		'{ROW_EVENT,  EV_SPARE5,  10'd1023, 1'b0, G_TAP},
		'{ROW_EVENT,  EV_SPARE6,  10'd682,  1'b0, G_TAP},
		'{ROW_EVENT,  EV_SPARE7,  10'd1023, 1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b1, G_TAP},
		'{ROW_EVENT,  EV_ABS_Y,   10'd1023, 1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd1023, 1'b1, G_DOWN},
		'{ROW_EVENT,  EV_PRESS,   10'd0,    1'b0, G_TAP},
		'{ROW_EVENT,  EV_ABS_Y,   10'd0,    1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b1, G_UP},
		// move of exactly the threshold on x, with y moved too
		'{ROW_EVENT,  EV_ABS_X,   10'd64,   1'b0, G_TAP},
		'{ROW_EVENT,  EV_ABS_Y,   10'd1023, 1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b0, G_TAP},
		// one short of the threshold
		'{ROW_EVENT,  EV_ABS_X,   10'd63,   1'b0, G_TAP},
		'{ROW_EVENT,  EV_ABS_Y,   10'd0,    1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b0, G_TAP},
		// zero threshold, release on the press point is still a tap
		'{ROW_THRESH, EV_NONE,    10'd0,    1'b0, G_TAP},
		'{ROW_EVENT,  EV_PRESS,   10'd0,    1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b1, G_TAP},
		'{ROW_EVENT,  EV_ABS_X,   10'd2,    1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b0, G_TAP},
		// full threshold, no move on screen reaches it
		'{ROW_THRESH, EV_NONE,    10'd1023, 1'b0, G_TAP},
		'{ROW_EVENT,  EV_ABS_X,   10'd1023, 1'b0, G_TAP},
		'{ROW_EVENT,  EV_RELEASE, 10'd0,    1'b1, G_TAP}
	};

	// clock, 20 ns period
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// predictor: applies one event word, returns 1 when it yields a gesture
	function automatic bit advance_touch(kind_t k, coord_t r, output gest_t g);
		int unsigned th;
		bit          yields;
		th     = thresh_now;
		yields = 1'b0;
		g      = G_TAP;
		case (k)
			// x scaled by 800/1024, truncated
			EV_ABS_X: begin
				now_pt.x = coord_t'((int'(r) * 800) / 1024);
			end
			// y scaled by 480/600, truncated
			EV_ABS_Y: begin
				now_pt.y = coord_t'((int'(r) * 480) / 600);
			end
			EV_PRESS: begin
				start_pt = now_pt;
			end
			EV_RELEASE: begin
				// right, left, down, up in that order, each needs a strict move
				if (start_pt.x < now_pt.x && (now_pt.x - start_pt.x) >= th) begin
					g = G_RIGHT;
				end else if (start_pt.x > now_pt.x && (start_pt.x - now_pt.x) >= th) begin
					g = G_LEFT;
				end else if (start_pt.y < now_pt.y && (now_pt.y - start_pt.y) >= th) begin
					g = G_DOWN;
				end else if (start_pt.y > now_pt.y && (start_pt.y - now_pt.y) >= th) begin
					g = G_UP;
				end
				start_pt = '0;
				yields   = 1'b1;
			end
			default: begin
				// ignored and unknown kinds change nothing
			end
		endcase
		return yields;
	endfunction

	// raw coordinate, either anywhere or a short hop from the last one
	function automatic coord_t hop_coord(coord_t last);
		int v;
		if ($urandom_range(0, 1) == 0) begin
			return coord_t'($urandom_range(0, 1023));
		end
		v = int'(last) + int'($urandom_range(0, 160)) - 80;
		if (v < 0) begin
			v = 0;
		end
		if (v > 1023) begin
			v = 1023;
		end
		return coord_t'(v);
	endfunction

	task automatic note_fault(string msg);
		fault_count++;
		if (fault_count <= 10) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	// one event word, called and returning at a falling edge; valid stays high
	// into the next word unless the sender idles
	task automatic send_event(kind_t k, coord_t r, bit fixed, gest_t g);
		while (!calm && $urandom_range(0, 99) < 8) begin
			evt_ch.valid <= 1'b0;
			@(negedge clk);
		end
		evt_ch.valid      <= 1'b1;
		evt_ch.event_kind <= k;
		evt_ch.raw_value  <= r;
		row_fixed = fixed;
		row_gest  = g;
		do
			@(posedge clk);
		while (!evt_ch.ready);
		words_sent++;
		@(negedge clk);
	endtask

	// sender pauses until every owed gesture is out, then lets the pipe empty
	task automatic settle_block();
		evt_ch.valid <= 1'b0;
		while (gesture_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(coord_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// gesture sink, ready drops now and then
	always @(negedge clk) begin
		if (!arst_n) begin
			gest_ch.ready <= 1'b0;
		end else begin
			gest_ch.ready <= calm || ($urandom_range(0, 99) >= 8);
		end
	end

	// monitor: check gestures, then predict from accepted words
	always @(posedge clk) begin
		gest_t g;
		gest_t want;
		if (arst_n) begin
			if (gest_ch.valid && gest_ch.ready) begin
				if (gesture_due.size() == 0) begin
					note_fault($sformatf("gesture word with none due, got %0d",
						gest_ch.gesture));
				end else begin
					want = gesture_due.pop_front();
					if (gest_ch.gesture !== want) begin
						note_fault($sformatf("gesture mismatch, expected %0d got %0d",
							want, gest_ch.gesture));
					end
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				thresh_now = cfg_ch.data;
			end
			if (evt_ch.valid && evt_ch.ready) begin
				// a typed row overrides the predicted code, state still advances
				if (advance_touch(evt_ch.event_kind, evt_ch.raw_value, g)) begin
					gesture_due.push_back(row_fixed ? row_gest : g);
				end
			end
		end
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#(2_000_000);
		$display("touch_swipe_classifier verification failed");
		$finish;
	end

	// stimulus
	initial begin
		coord_t      th_list [5];
		coord_t      last_x;
		coord_t      last_y;
		coord_t      raw;
		int unsigned phase_goal;
		bit          paused_once;

		// known values from time zero, reset held low at the start
		arst_n            = 1'b0;
		evt_ch.valid      = 1'b0;
		evt_ch.event_kind = EV_NONE;
		evt_ch.raw_value  = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.data       = '0;
		gest_ch.ready     = 1'b0;
		now_pt            = '0;
		start_pt          = '0;
		thresh_now        = THRESH_RESET;
		row_fixed         = 1'b0;
		row_gest          = G_TAP;
		calm              = 1'b0;
		words_sent        = 0;
		fault_count       = 0;
		last_x            = '0;
		last_y            = '0;
		paused_once       = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < NROWS; i++) begin
			if (plan[i].op == ROW_THRESH) begin
				settle_block();
				write_threshold(plan[i].value);
			end else begin
				send_event(plan[i].kind, plan[i].value, plan[i].fixed, plan[i].gest);
			end
		end

		// random phases, one threshold each: zero, small, full, mid, small
		th_list[0] = 10'd0;
		th_list[1] = coord_t'($urandom_range(1, 200));
		th_list[2] = 10'd1023;
		th_list[3] = coord_t'($urandom_range(200, 600));
		th_list[4] = coord_t'($urandom_range(1, 100));
		phase_goal = words_sent;

		for (int p = 0; p < 5; p++) begin
			settle_block();
			write_threshold(th_list[p]);
			// second phase runs with no idling on either side
			calm = (p == 1);
			phase_goal += PHASE_WORDS;
			while (words_sent < phase_goal) begin
				// once, mid phase, stall the sender until the block has drained
				if (!paused_once && p == 3 && words_sent + PHASE_WORDS / 2 >= phase_goal) begin
					settle_block();
					paused_once = 1'b1;
				end
				if ($urandom_range(0, 99) < 85) begin
					// stroke: a few moves, press, a few moves, release
					repeat ($urandom_range(0, 2)) begin
						if ($urandom_range(0, 1) == 0) begin
							last_x = coord_t'($urandom_range(0, 1023));
							send_event(EV_ABS_X, last_x, 1'b0, G_TAP);
						end else begin
							last_y = coord_t'($urandom_range(0, 1023));
							send_event(EV_ABS_Y, last_y, 1'b0, G_TAP);
						end
					end
					send_event(EV_PRESS, coord_t'($urandom_range(0, 1023)), 1'b0, G_TAP);
					repeat ($urandom_range(1, 4)) begin
						if ($urandom_range(0, 1) == 0) begin
							last_x = hop_coord(last_x);
							send_event(EV_ABS_X, last_x, 1'b0, G_TAP);
						end else begin
							last_y = hop_coord(last_y);
							send_event(EV_ABS_Y, last_y, 1'b0, G_TAP);
						end
					end
					send_event(EV_RELEASE, coord_t'($urandom_range(0, 1023)), 1'b0, G_TAP);
				end else begin
					// noise: any kind, any raw value
					repeat ($urandom_range(1, 3)) begin
						raw = coord_t'($urandom_range(0, 1023));
						send_event(kind_t'($urandom_range(0, 7)), raw, 1'b0, G_TAP);
					end
				end
			end
		end

		// drain, then keep watching to catch stray gestures
		calm = 1'b0;
		settle_block();
		repeat (8) @(negedge clk);
		if (gesture_due.size() != 0) begin
			note_fault($sformatf("%0d gesture words never arrived", gesture_due.size()));
		end
		if (fault_count == 0) begin
			$display("touch_swipe_classifier verification clean");
		end else begin
			$display("touch_swipe_classifier verification failed");
		end
		$finish;
	end

endmodule

### files.f
rtl/tsc_pkg.sv
rtl/tsc_event_if.sv
rtl/tsc_gesture_if.sv
rtl/tsc_cfg_if.sv
rtl/tsc_classify.sv
rtl/touch_swipe_classifier.sv
verif/touch_swipe_classifier_test.sv
